>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define CHT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// clocked check, active during reset as well
`define CHT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("assertion failed");

`endif

>>> hw/rtl/cht_pkg.sv
// types and constants shared by the chained hash table engine
package cht_pkg;

    localparam logic [31:0] HASH_SEED  = 32'd3323198485;
    localparam logic [31:0] HASH_MUL   = 32'h5bd1e995;
    localparam int          HASH_SHIFT = 15;

    localparam logic [5:0] TABLE_SIZE_RST = 6'd16;
    localparam logic [7:0] MAX_WORDS_RST  = 8'd200;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_CHAIN_FULL = 3'd3,
        ST_WORD_LIMIT = 3'd4,
        ST_BAD_BUCKET = 3'd5,
        ST_BAD_POS    = 3'd6
    } t_status;

    typedef enum logic {
        REG_TABLE_SIZE = 1'b0,
        REG_MAX_WORDS  = 1'b1
    } t_reg;

    typedef struct packed {
        logic clear;
        logic len_rd;
        logic len_wr;
        logic st_rd;
        logic st_wr;
    } t_tbl_ctl;

endpackage

>>> hw/rtl/cht_hash.sv
// hash accumulator: xor and multiply into a product register, then a shift-xor mix into the hash register
module cht_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    input  logic        i_clear,
    output logic        o_done,
    output logic [31:0] o_hash
);
    import cht_pkg::*;

    logic [31:0] r_acc;
    logic [31:0] r_prod;
    logic [31:0] r_h;
    logic        r_pend;
    logic        r_last;
    logic        r_done;
    logic [31:0] mixed;

    assign mixed = r_prod ^ (r_prod >> HASH_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= HASH_SEED;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_clear) begin
                r_acc <= HASH_SEED;
            end
            if (i_start) begin
                r_prod <= (r_acc ^ {24'd0, i_char}) * HASH_MUL;
                r_last <= i_last;
                r_pend <= 1'b1;
            end
            if (r_pend) begin
                r_h    <= mixed;
                r_acc  <= r_last ? HASH_SEED : mixed;
                r_pend <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h;
endmodule

>>> hw/rtl/cht_rem.sv
// iterative remainder unit, one dividend bit per cycle
module cht_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [5:0]  i_divisor,
    output logic        o_done,
    output logic [5:0]  o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [5:0]  r_rem;
    logic [5:0]  r_div;
    logic [6:0]  trial;
    logic [6:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_q[31]};
        n_rem = (trial >= {1'b0, r_div}) ? (trial - {1'b0, r_div}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_q    <= i_dividend;
                r_rem  <= 6'd0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem[5:0];
                r_q   <= {r_q[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

>>> hw/rtl/cht_tables.sv
// chain length memory with valid bits and chain entry memory
module cht_tables #(
    parameter int TABLE_SLOTS = 32,
    parameter int CHAIN_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cht_pkg::t_tbl_ctl                 i_ctl,
    input  logic [$clog2(TABLE_SLOTS)-1:0]    i_bucket,
    input  logic [$clog2(CHAIN_DEPTH)-1:0]    i_idx,
    input  logic [$clog2(CHAIN_DEPTH+1)-1:0]  i_len_wdata,
    input  logic [31:0]                       i_st_wdata,
    output logic [$clog2(CHAIN_DEPTH+1)-1:0]  o_len,
    output logic [31:0]                       o_st_data
);
    import cht_pkg::*;

    localparam int LW = $clog2(CHAIN_DEPTH + 1);
    localparam int AW = $clog2(TABLE_SLOTS * CHAIN_DEPTH);

    logic [LW-1:0]      r_len_mem [TABLE_SLOTS];
    logic               r_len_vld [TABLE_SLOTS];
    logic [31:0]        r_st_mem  [TABLE_SLOTS * CHAIN_DEPTH];
    logic [LW-1:0]      r_len_q;
    logic [31:0]        r_st_q;
    logic [AW-1:0]      st_addr;

    assign st_addr = AW'(32'(i_bucket) * 32'(CHAIN_DEPTH) + 32'(i_idx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_len_vld[i] <= 1'b0;
            end
        end else if (i_ctl.clear) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_len_vld[i] <= 1'b0;
            end
        end else if (i_ctl.len_wr) begin
            r_len_vld[i_bucket] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.len_wr) begin
            r_len_mem[i_bucket] <= i_len_wdata;
        end
        if (i_ctl.len_rd) begin
            r_len_q <= r_len_vld[i_bucket] ? r_len_mem[i_bucket] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.st_wr) begin
            r_st_mem[st_addr] <= i_st_wdata;
        end
        if (i_ctl.st_rd) begin
            r_st_q <= r_st_mem[st_addr];
        end
    end

    assign o_len     = r_len_q;
    assign o_st_data = r_st_q;
endmodule

>>> hw/rtl/chained_hash_table_engine.sv
// chained hash table engine top level
// input channel: one item per key byte (insert or find), or one read or clear
// item. the hash folds each byte; the byte marked last selects a bucket and
// inserts or looks up the hash in that bucket's chain.
// output channel: one item per last key byte, read or clear; none for other
// key bytes.
// a non-final byte only passes through the hash; a final byte then runs the
// bit-serial remainder, reads the chain length and compares chain entries in
// turn, taking one more step when the walk ends without a match.
// read by position checks bucket and position, then reads the entry; clear
// goes to output. the result is valid in the same cycle the input is free.
// one item is in work at a time; o_in_stall is high while it is.
// a finished item waits in the output register while the receiver stalls and
// the block holds its final step until that register is free.
// reset clears all chains, the word count and the hash accumulator and loads
// table_size 16 and max_words 200; no clearing pass is needed.
// registers on the apb port: table_size at 0x0, max_words at 0x4.
module chained_hash_table_engine #(
    parameter int TABLE_SLOTS = 32,
    parameter int CHAIN_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_key_char,
    input  logic        i_last,
    input  logic [4:0]  i_bucket,
    input  logic [4:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_found_bucket,
    output logic [4:0]  o_found_position,
    output logic [31:0] o_hash_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cht_pkg::*;

    localparam int BW = $clog2(TABLE_SLOTS);
    localparam int IW = $clog2(CHAIN_DEPTH);
    localparam int LW = $clog2(CHAIN_DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_HASH = 11'b00000000010,
        S_DIV  = 11'b00000000100,
        S_LRD  = 11'b00000001000,
        S_LCHK = 11'b00000010000,
        S_WALK = 11'b00000100000,
        S_ENDS = 11'b00001000000,
        S_RCHK = 11'b00010000000,
        S_RLEN = 11'b00100000000,
        S_RDAT = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    t_op           r_op;
    logic [4:0]    r_rb;
    logic [4:0]    r_rp;
    logic [BW-1:0] r_bk;
    logic [LW-1:0] r_len;
    logic [IW-1:0] r_idx;
    logic [7:0]    r_wc;
    logic [5:0]    r_ts;
    logic [7:0]    r_mw;
    t_status       r_res_status;
    logic [4:0]    r_res_bk;
    logic [4:0]    r_res_pos;
    logic [31:0]   r_res_hash;
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [4:0]    r_out_bk;
    logic [4:0]    r_out_pos;
    logic [31:0]   r_out_hash;

    logic          accept;
    logic          cfg_wr;
    logic [5:0]    eff;
    logic          hash_start;
    logic          hash_done;
    logic [31:0]   hash;
    logic          rem_start;
    logic          rem_done;
    logic [5:0]    rem;
    t_tbl_ctl      tctl;
    logic [IW-1:0] tidx;
    logic [LW-1:0] tlen;
    logic [31:0]   tdata;
    logic          hit;
    logic          walk_end;
    logic          out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !r_out_valid || !i_out_stall;
    assign hit      = (tdata == hash);
    assign walk_end = (32'(r_idx) + 32'd1) >= 32'(r_len);

    always_comb begin
        eff = r_ts;
        if (r_ts == 6'd0) begin
            eff = 6'd1;
        end else if (32'(r_ts) > TABLE_SLOTS) begin
            eff = 6'(TABLE_SLOTS);
        end
    end

    assign hash_start = accept && (i_operation == OP_INSERT || i_operation == OP_FIND);
    assign rem_start  = (r_state == S_HASH) && hash_done && r_res_status == ST_OK
                        && r_op != OP_READ && r_rp[0];

    cht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_char  (i_key_char),
        .i_last  (i_last),
        .i_clear (accept && i_operation == OP_CLEAR),
        .o_done  (hash_done),
        .o_hash  (hash)
    );

    cht_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (hash),
        .i_divisor  (eff),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    always_comb begin
        tctl  = '0;
        tidx  = '0;
        case (r_state)
            S_LRD:  tctl.len_rd = 1'b1;
            S_RCHK: tctl.len_rd = ({27'd0, r_rb} < {26'd0, eff});
            S_LCHK: tctl.st_rd = 1'b1;
            S_WALK: begin
                tctl.st_rd = 1'b1;
                tidx       = r_idx + IW'(1);
            end
            S_RLEN: begin
                tctl.st_rd = 1'b1;
                tidx       = IW'(r_rp - 5'd1);
            end
            S_ENDS: begin
                if (r_op == OP_INSERT && 32'(r_len) < CHAIN_DEPTH) begin
                    tctl.len_wr = 1'b1;
                    tctl.st_wr  = 1'b1;
                    tidx        = IW'(r_len);
                end
            end
            default: tctl.clear = accept && i_operation == OP_CLEAR;
        endcase
    end

    cht_tables #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .CHAIN_DEPTH (CHAIN_DEPTH)
    ) u_tables (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tctl),
        .i_bucket    (r_bk),
        .i_idx       (tidx),
        .i_len_wdata (r_len + LW'(1)),
        .i_st_wdata  (hash),
        .o_len       (tlen),
        .o_st_data   (tdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_CLEAR: n_state = S_OUT;
                        OP_READ:  n_state = S_RCHK;
                        default:  n_state = S_HASH;
                    endcase
                end
            end
            S_HASH: if (hash_done) n_state = r_rp[0] ? S_DIV : S_IDLE;
            S_DIV:  if (rem_done) n_state = S_LRD;
            S_LRD:  n_state = S_LCHK;
            S_LCHK: begin
                if (r_op == OP_INSERT && r_wc >= r_mw) begin
                    n_state = S_OUT;
                end else if (tlen == '0) begin
                    n_state = S_ENDS;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (hit) begin
                    n_state = S_OUT;
                end else if (walk_end) begin
                    n_state = S_ENDS;
                end
            end
            S_ENDS: n_state = S_OUT;
            S_RCHK: n_state = ({27'd0, r_rb} >= {26'd0, eff}) ? S_OUT : S_RLEN;
            S_RLEN: begin
                if (r_rp == 5'd0 || 32'(r_rp) > 32'(tlen)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RDAT;
                end
            end
            S_RDAT: n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wc        <= 8'd0;
            r_ts        <= TABLE_SIZE_RST;
            r_mw        <= MAX_WORDS_RST;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (t_reg'(paddr[2]))
                    REG_TABLE_SIZE: r_ts <= pwdata[5:0];
                    REG_MAX_WORDS:  r_mw <= pwdata[7:0];
                    default:        r_ts <= r_ts;
                endcase
            end
            if (accept && i_operation == OP_CLEAR) begin
                r_wc <= 8'd0;
            end
            if (r_state == S_ENDS && tctl.st_wr) begin
                r_wc <= r_wc + 8'd1;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= t_op'(i_operation);
            r_rb         <= i_bucket;
            r_rp         <= (i_operation == OP_READ) ? i_position : {4'd0, i_last};
            r_bk         <= BW'(i_bucket);
            r_res_status <= ST_OK;
            r_res_bk     <= (i_operation == OP_READ) ? i_bucket : 5'd0;
            r_res_pos    <= (i_operation == OP_READ) ? i_position : 5'd0;
            r_res_hash   <= 32'd0;
        end
        case (r_state)
            S_DIV: begin
                if (rem_done) begin
                    r_bk     <= BW'(rem);
                    r_res_bk <= 5'(rem);
                end
                r_res_hash <= hash;
            end
            S_LCHK: begin
                r_len <= tlen;
                r_idx <= '0;
                if (r_op == OP_INSERT && r_wc >= r_mw) begin
                    r_res_status <= ST_WORD_LIMIT;
                end
            end
            S_WALK: begin
                if (hit) begin
                    r_res_status <= (r_op == OP_FIND) ? ST_OK : ST_DUPLICATE;
                    r_res_pos    <= 5'(32'(r_idx) + 32'd1);
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            S_ENDS: begin
                if (r_op == OP_FIND) begin
                    r_res_status <= ST_NOT_FOUND;
                end else if (32'(r_len) >= CHAIN_DEPTH) begin
                    r_res_status <= ST_CHAIN_FULL;
                end else begin
                    r_res_pos <= 5'(32'(r_len) + 32'd1);
                end
            end
            S_RCHK: begin
                if ({27'd0, r_rb} >= {26'd0, eff}) begin
                    r_res_status <= ST_BAD_BUCKET;
                end
            end
            S_RLEN: begin
                if (r_rp == 5'd0 || 32'(r_rp) > 32'(tlen)) begin
                    r_res_status <= ST_BAD_POS;
                end
            end
            S_RDAT: r_res_hash <= tdata;
            S_OUT: begin
                if (out_free) begin
                    r_out_status <= r_res_status;
                    r_out_bk     <= r_res_bk;
                    r_out_pos    <= r_res_pos;
                    r_out_hash   <= r_res_hash;
                end
            end
            default: r_idx <= r_idx;
        endcase
    end

    always_comb begin
        case (t_reg'(paddr[2]))
            REG_TABLE_SIZE: prdata = {26'd0, r_ts};
            REG_MAX_WORDS:  prdata = {24'd0, r_mw};
            default:        prdata = 32'd0;
        endcase
    end

    assign pready           = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_bucket   = r_out_bk;
    assign o_found_position = r_out_pos;
    assign o_hash_value     = r_out_hash;
endmodule

>>> hw/rtl/cht_checker.sv
// port-level checks for the chained hash table engine, bound to the top level
`include "assert_macros.svh"

module cht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [4:0]  o_found_position,
    input logic [31:0] o_hash_value
);
    import cht_pkg::*;

    `CHT_ASSERT(a_status_range, o_out_valid |-> o_status <= ST_BAD_POS)
    `CHT_ASSERT(a_bad_read_zero_hash, (o_out_valid && (o_status == ST_BAD_BUCKET || o_status == ST_BAD_POS)) |-> o_hash_value == 32'd0)
    `CHT_ASSERT(a_miss_no_position, (o_out_valid && (o_status == ST_NOT_FOUND || o_status == ST_CHAIN_FULL || o_status == ST_WORD_LIMIT)) |-> o_found_position == 5'd0)
    `CHT_ASSERT(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `CHT_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid)
endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (.*);
